// File: design/disr_pkg.sv
// ----------------------------------------------------------------------------
// disr_pkg
// Shared widths, register indexes, state encoding and controller/datapath
// command and status bundles for the depth image residual statistics block.
// ----------------------------------------------------------------------------
package disr_pkg;

  // default parameter values
  localparam int MAX_PIXELS_DEF      = 1048576;
  localparam int RATIO_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int DEPTH_W     = 16;
  localparam int THRESH_W    = 18;
  localparam int COUNT_W     = 21;
  localparam int SUM_W       = 38;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 18;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INLIER_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_MODE    = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic acc;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rel;
    logic div_last;
    logic last;
    logic out_free;
  } status_t;

  // count saturation point: smaller of the pixel limit and the field maximum
  function automatic logic [COUNT_W-1:0] count_cap(input int max_pixels);
    logic [COUNT_W-1:0] cap;
    if (max_pixels < (2 ** COUNT_W) - 1) begin
      cap = COUNT_W'(max_pixels);
    end else begin
      cap = {COUNT_W{1'b1}};
    end
    return cap;
  endfunction

endpackage

// File: design/disr_dp.sv
// ----------------------------------------------------------------------------
// disr_dp
// Datapath: pixel pair capture, restoring divider for the relative residual,
// saturating inlier/outlier accumulators and the output register.
// ----------------------------------------------------------------------------
module disr_dp #(
  parameter int MAX_PIXELS      = disr_pkg::MAX_PIXELS_DEF,
  parameter int RATIO_FRAC_BITS = disr_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  disr_pkg::cmd_t                      cmd,
  output disr_pkg::status_t                   st,
  input  logic [disr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tlast,
  input  logic [disr_pkg::THRESH_W-1:0]       inlier_threshold,
  input  logic                                relative_mode,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [disr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int DW     = disr_pkg::DEPTH_W;
  localparam int QW     = RATIO_FRAC_BITS + 2;
  localparam int EW     = (QW > DW) ? QW : DW;
  localparam int CW     = (EW > disr_pkg::THRESH_W) ? EW : disr_pkg::THRESH_W;
  localparam int RW     = DW + 2;
  localparam int STEP_W = $clog2(QW);
  localparam int SW     = disr_pkg::SUM_W;
  localparam int NW     = disr_pkg::COUNT_W;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);
  localparam logic [NW-1:0]     COUNT_CAP = disr_pkg::count_cap(MAX_PIXELS);
  localparam logic [SW:0]       SUM_MAX   = {1'b0, {SW{1'b1}}};

  // captured pair
  logic [DW-1:0]     diff;
  logic [DW:0]       total;
  logic              used;
  logic              last;
  // divider
  logic [RW-1:0]     rem;
  logic [QW-1:0]     quo;
  logic [STEP_W-1:0] step;
  // accumulators
  logic [NW-1:0]     in_cnt;
  logic [SW-1:0]     in_sum;
  logic [NW-1:0]     out_cnt;
  logic [SW-1:0]     out_sum;
  // output register
  logic [NW-1:0]     res_in_cnt;
  logic [SW-1:0]     res_in_sum;
  logic [NW-1:0]     res_out_cnt;
  logic [SW-1:0]     res_out_sum;

  logic [DW-1:0]     a;
  logic [DW-1:0]     b;
  logic [DW-1:0]     diff_next;
  logic [RW-1:0]     rem_shift;
  logic              rem_ge;
  logic [EW-1:0]     resid;
  logic              is_inlier;
  logic [SW:0]       in_sum_add;
  logic [SW:0]       out_sum_add;
  logic [SW-1:0]     in_sum_next;
  logic [SW-1:0]     out_sum_next;
  logic [NW-1:0]     in_cnt_next;
  logic [NW-1:0]     out_cnt_next;

  // input unpack and absolute difference
  assign a         = s_tdata[15:0];
  assign b         = s_tdata[32:17];
  assign diff_next = (a > b) ? (a - b) : (b - a);

  // one quotient bit per step; the first step takes the integer bit unshifted
  assign rem_shift = (step == '0) ? rem : {rem[RW-2:0], 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, total});

  // residual select, zero mean gives zero
  always_comb begin
    if (!relative_mode) begin
      resid = EW'(diff);
    end else if (total == '0) begin
      resid = '0;
    end else begin
      resid = EW'(quo);
    end
  end

  assign is_inlier = (CW'(resid) < CW'(inlier_threshold));

  // saturating updates
  assign in_sum_add   = {1'b0, in_sum} + (SW + 1)'(resid);
  assign out_sum_add  = {1'b0, out_sum} + (SW + 1)'(resid);
  assign in_sum_next  = (in_sum_add >= SUM_MAX) ? SUM_MAX[SW-1:0] : in_sum_add[SW-1:0];
  assign out_sum_next = (out_sum_add >= SUM_MAX) ? SUM_MAX[SW-1:0] : out_sum_add[SW-1:0];
  assign in_cnt_next  = (in_cnt >= COUNT_CAP) ? COUNT_CAP : in_cnt + 1'b1;
  assign out_cnt_next = (out_cnt >= COUNT_CAP) ? COUNT_CAP : out_cnt + 1'b1;

  // pair capture and divider iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff  <= diff_next;
      total <= {1'b0, a} + {1'b0, b};
      used  <= s_tdata[16] & s_tdata[33];
      last  <= s_tlast;
      rem   <= RW'(diff_next);
      quo   <= '0;
      step  <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_shift - RW'(total)) : rem_shift;
      quo  <= {quo[QW-2:0], rem_ge};
      step <= step + 1'b1;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      in_sum  <= '0;
      out_cnt <= '0;
      out_sum <= '0;
    end else if (cmd.emit) begin
      in_cnt  <= '0;
      in_sum  <= '0;
      out_cnt <= '0;
      out_sum <= '0;
    end else if (cmd.acc && used) begin
      if (is_inlier) begin
        in_cnt <= in_cnt_next;
        in_sum <= in_sum_next;
      end else begin
        out_cnt <= out_cnt_next;
        out_sum <= out_sum_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_in_cnt  <= in_cnt;
      res_in_sum  <= in_sum;
      res_out_cnt <= out_cnt;
      res_out_sum <= out_sum;
    end
  end

  assign m_tdata = {2'b00, res_out_sum, res_out_cnt, res_in_sum, res_in_cnt};

  // status
  assign st.rel      = relative_mode;
  assign st.div_last = (step == LAST_STEP);
  assign st.last     = last;
  assign st.out_free = !m_tvalid || m_tready;

endmodule

// File: design/disr_ctrl.sv
// ----------------------------------------------------------------------------
// disr_ctrl
// Controller: sequences capture, division, accumulation and result hand-off
// for one pixel pair at a time.
// ----------------------------------------------------------------------------
module disr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  disr_pkg::status_t   st,
  output disr_pkg::cmd_t      cmd,
  output disr_pkg::state_t    state
);

  disr_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= disr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      disr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = st.rel ? disr_pkg::ST_DIV : disr_pkg::ST_ACC;
        end
      end
      disr_pkg::ST_DIV: begin
        if (st.div_last) begin
          state_next = disr_pkg::ST_ACC;
        end
      end
      disr_pkg::ST_ACC: begin
        state_next = st.last ? disr_pkg::ST_EMIT : disr_pkg::ST_IDLE;
      end
      disr_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = disr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = disr_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      disr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      disr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      disr_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
      end
      disr_pkg::ST_EMIT: begin
        cmd.emit = st.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: design/depth_image_residual_stats.sv
// ----------------------------------------------------------------------------
// depth_image_residual_stats
// Inlier/outlier residual statistics over co-located pixel pairs of two
// depth images.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one pixel pair per transfer, s_tlast marks the last pixel of
//   the frame. Pairs with both valid flags set add their residual (absolute
//   depth difference, or difference over mean depth as a fixed-point ratio in
//   relative mode) to the inlier or outlier totals against inlier_threshold.
//   After the last pixel one transfer on m_* carries the four totals, which
//   are then cleared. cfg_* writes inlier_threshold (index 0) and
//   relative_mode (index 1); cfg_ready is always high.
// processing
//   One pair is processed at a time. Absolute mode: each pair passes the
//   load and accumulate states. Relative mode: each pair also passes the
//   divider states, where the restoring divider retires one quotient bit per cycle.
//   The last pixel of a frame then passes the emit state to load the result.
// reset and stall
//   rst clears the totals, the registers and the output. While m_tready is
//   low a pending result is held and the next pair is still taken; the block
//   waits only when the following frame's result is ready to load.
// ----------------------------------------------------------------------------
module depth_image_residual_stats #(
  parameter int MAX_PIXELS      = disr_pkg::MAX_PIXELS_DEF,
  parameter int RATIO_FRAC_BITS = disr_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [disr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [disr_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel pair stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // depth_a[15:0], valid_a[16], depth_b[32:17], valid_b[33], zero pad
  input  logic [disr_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tlast,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // inlier_count[20:0], inlier_sum[58:21], outlier_count[79:59],
  // outlier_sum[117:80], zero pad
  output logic [disr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam logic [disr_pkg::COUNT_W-1:0] COUNT_CAP = disr_pkg::count_cap(MAX_PIXELS);

  logic [disr_pkg::THRESH_W-1:0] inlier_threshold;
  logic                          relative_mode;
  disr_pkg::cmd_t                cmd;
  disr_pkg::status_t             st;
  disr_pkg::state_t              state;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inlier_threshold <= '0;
      relative_mode    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        disr_pkg::REG_INLIER_THRESHOLD: inlier_threshold <= cfg_data;
        disr_pkg::REG_RELATIVE_MODE:    relative_mode    <= cfg_data[0];
        default: begin
          relative_mode <= relative_mode;
        end
      endcase
    end
  end

  // controller
  disr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath
  disr_dp #(
    .MAX_PIXELS      (MAX_PIXELS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .inlier_threshold (inlier_threshold),
    .relative_mode    (relative_mode),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .m_tdata          (m_tdata)
  );

  // counts never pass the saturation point
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:0] <= COUNT_CAP) && (m_tdata[79:59] <= COUNT_CAP))
    else $error("result count above saturation point");

  // a new result appears only out of the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == disr_pkg::ST_EMIT))
    else $error("result raised outside emit");

  // one pair in flight: no transfer in the cycle after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a pair is in progress");

endmodule

// File: verif/depth_image_residual_stats_test.sv
// ----------------------------------------------------------------------------
// depth_image_residual_stats_test
// Self-checking bench for the residual statistics block. Pixel pairs stream
// in from a queue with random gaps, the result side stalls at random, and a
// local predictor computes the expected frame totals, which are compared
// field by field with every result transfer. Runs several threshold and mode
// settings: directed edge cases first, then random frames.
// ----------------------------------------------------------------------------
module depth_image_residual_stats_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SUM_LIMIT   = (64'd1 << disr_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] COUNT_LIMIT =
    (disr_pkg::MAX_PIXELS_DEF < (2 ** disr_pkg::COUNT_W) - 1) ?
    64'(disr_pkg::MAX_PIXELS_DEF) : 64'((2 ** disr_pkg::COUNT_W) - 1);
  localparam int SETTLE_CYCLES = 25;

  typedef struct {
    logic [disr_pkg::DEPTH_W-1:0] depth_a;
    logic                         valid_a;
    logic [disr_pkg::DEPTH_W-1:0] depth_b;
    logic                         valid_b;
    logic                         frame_end;
  } pixel_pair_t;

  typedef struct {
    logic [disr_pkg::COUNT_W-1:0] inlier_count;
    logic [disr_pkg::SUM_W-1:0]   inlier_sum;
    logic [disr_pkg::COUNT_W-1:0] outlier_count;
    logic [disr_pkg::SUM_W-1:0]   outlier_sum;
  } frame_totals_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [disr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [disr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [disr_pkg::IN_TDATA_W-1:0] s_tdata  = '0;
  logic                            s_tlast  = 1'b0;

  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [disr_pkg::OUT_TDATA_W-1:0] m_tdata;

  // stimulus and expectation stores
  pixel_pair_t   pending_pairs[$];
  frame_totals_t expected_totals[$];
  pixel_pair_t   pair_on_bus;

  // predictor copy of registers and running totals
  logic [disr_pkg::THRESH_W-1:0] thresh_setting   = '0;
  logic                          relative_setting = 1'b0;
  logic [63:0]         tot_in_count  = '0;
  logic [63:0]         tot_in_sum    = '0;
  logic [63:0]         tot_out_count = '0;
  logic [63:0]         tot_out_sum   = '0;

  int unsigned mismatches = 0;
  int          send_gap   = 0;
  int          stall_left = 0;
  bit          src_steady = 1'b0;
  bit          snk_steady = 1'b0;

  depth_image_residual_stats u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // residual of one pair: absolute difference or truncated ratio to mean depth
  function automatic logic [63:0] pair_residual(logic [disr_pkg::DEPTH_W-1:0] a,
                                                 logic [disr_pkg::DEPTH_W-1:0] b,
                                                 logic rel);
    logic [63:0] diff;
    logic [63:0] total;
    diff  = (a > b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
    total = 64'(a) + 64'(b);
    if (!rel) begin
      return diff;
    end
    if (total == '0) begin
      return '0;
    end
    return (diff << (disr_pkg::RATIO_FRAC_BITS_DEF + 1)) / total;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] v);
    if (v >= SUM_LIMIT || acc >= SUM_LIMIT - v) begin
      return SUM_LIMIT;
    end
    return acc + v;
  endfunction

  function automatic logic [63:0] sat_count(logic [63:0] acc);
    return (acc >= COUNT_LIMIT) ? COUNT_LIMIT : acc + 64'd1;
  endfunction

  // fold one pair into the totals; returns 1 with the frame totals on frame end
  function automatic bit accumulate_pair(pixel_pair_t p, output frame_totals_t t);
    logic [63:0] e;
    t = '{default: '0};
    if (p.valid_a && p.valid_b) begin
      e = pair_residual(p.depth_a, p.depth_b, relative_setting);
      if (e < 64'(thresh_setting)) begin
        tot_in_count = sat_count(tot_in_count);
        tot_in_sum   = sat_sum(tot_in_sum, e);
      end else begin
        tot_out_count = sat_count(tot_out_count);
        tot_out_sum   = sat_sum(tot_out_sum, e);
      end
    end
    if (!p.frame_end) begin
      return 1'b0;
    end
    t.inlier_count  = tot_in_count[disr_pkg::COUNT_W-1:0];
    t.inlier_sum    = tot_in_sum[disr_pkg::SUM_W-1:0];
    t.outlier_count = tot_out_count[disr_pkg::COUNT_W-1:0];
    t.outlier_sum   = tot_out_sum[disr_pkg::SUM_W-1:0];
    tot_in_count  = '0;
    tot_in_sum    = '0;
    tot_out_count = '0;
    tot_out_sum   = '0;
    return 1'b1;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_pair(int a, bit va, int b, bit vb, bit last);
    pixel_pair_t p;
    p.depth_a   = a[disr_pkg::DEPTH_W-1:0];
    p.valid_a   = va;
    p.depth_b   = b[disr_pkg::DEPTH_W-1:0];
    p.valid_b   = vb;
    p.frame_end = last;
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // random pair: mostly close depths so residuals land near the threshold
  function automatic void add_random_pair(bit last);
    int kind;
    int a;
    int b;
    int delta;
    int vsel;
    kind = $urandom_range(0, 9);
    a    = $urandom_range(0, 65535);
    b    = $urandom_range(0, 65535);
    if (kind == 1) begin
      a = $urandom_range(0, 1) ? 65535 : 0;
      b = $urandom_range(0, 1) ? 65535 : 0;
    end else if (kind == 2) begin
      a = $urandom_range(0, 15);
      b = $urandom_range(0, 15);
    end else if (kind > 2) begin
      delta = $urandom_range(0, 1 << $urandom_range(0, 12));
      if ($urandom_range(0, 1)) begin
        b = (a + delta > 65535) ? 65535 : a + delta;
      end else begin
        b = (a < delta) ? 0 : a - delta;
      end
    end
    vsel = $urandom_range(0, 99);
    if (vsel < 85) begin
      add_pair(a, 1'b1, b, 1'b1, last);
    end else begin
      add_pair(a, 1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)), last);
    end
  endfunction

  // one register write over the configuration channel
  task automatic write_reg(logic [disr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [disr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == disr_pkg::REG_INLIER_THRESHOLD) begin
      thresh_setting = val;
    end else if (idx == disr_pkg::REG_RELATIVE_MODE) begin
      relative_setting = val[0];
    end
    cfg_valid <= 1'b0;
  endtask

  // wait until every pair went out and every frame result came back
  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || s_tvalid || expected_totals.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void check_field(string field_name, logic [63:0] want,
                                      logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field_name, want, got);
    end
  endfunction

  // pixel pair driver
  always @(posedge clk) begin
    frame_totals_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (accumulate_pair(pair_on_bus, t)) begin
          expected_totals.insert(expected_totals.size(), t);
        end
      end
      if (s_tvalid && !s_tready) begin
        // hold the pending transfer
      end else if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_pairs.size() != 0) begin
        pair_on_bus = pending_pairs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(disr_pkg::IN_TDATA_W - 34){1'b0}}, pair_on_bus.valid_b,
                     pair_on_bus.depth_b, pair_on_bus.valid_a, pair_on_bus.depth_a};
        s_tlast  <= pair_on_bus.frame_end;
        send_gap = src_steady ? 0 : idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    frame_totals_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_totals.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        end else begin
          want = expected_totals.pop_front();
          check_field("inlier_count", 64'(want.inlier_count), 64'(m_tdata[20:0]));
          check_field("inlier_sum", 64'(want.inlier_sum), 64'(m_tdata[58:21]));
          check_field("outlier_count", 64'(want.outlier_count), 64'(m_tdata[79:59]));
          check_field("outlier_sum", 64'(want.outlier_sum), 64'(m_tdata[117:80]));
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = snk_steady ? 0 : idle_len();
      end
    end
  end

  // stimulus sequence
  initial begin
    int phase;
    int pairs;
    int len;
    int r;
    logic [disr_pkg::THRESH_W-1:0] thresh;
    bit rel;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero threshold, everything is an outlier
    add_pair(0, 1'b1, 0, 1'b1, 1'b0);
    add_pair(65535, 1'b1, 0, 1'b1, 1'b0);
    add_pair(0, 1'b1, 65535, 1'b0, 1'b0);
    add_pair(123, 1'b0, 456, 1'b1, 1'b1);
    // frame of one unused pair still emits zero totals
    add_pair(7, 1'b0, 9, 1'b0, 1'b1);
    drain();

    // absolute mode, differences around the threshold
    write_reg(disr_pkg::REG_INLIER_THRESHOLD, 18'd1000);
    write_reg(disr_pkg::REG_RELATIVE_MODE, {17'($urandom), 1'b0});
    add_pair(5000, 1'b1, 5999, 1'b1, 1'b0);
    add_pair(6000, 1'b1, 5000, 1'b1, 1'b0);
    add_pair(5000, 1'b1, 6001, 1'b1, 1'b0);
    add_pair(65535, 1'b1, 65535, 1'b1, 1'b0);
    add_pair(0, 1'b1, 65535, 1'b1, 1'b1);
    add_pair(300, 1'b1, 301, 1'b1, 1'b1);
    drain();

    // relative mode: full ratio, zero mean, zero difference
    write_reg(disr_pkg::REG_RELATIVE_MODE, {17'($urandom), 1'b1});
    write_reg(disr_pkg::REG_INLIER_THRESHOLD, 18'd131072);
    add_pair(0, 1'b1, 65535, 1'b1, 1'b0);
    add_pair(1, 1'b1, 65535, 1'b1, 1'b0);
    add_pair(0, 1'b1, 0, 1'b1, 1'b0);
    add_pair(65535, 1'b1, 65535, 1'b1, 1'b0);
    add_pair(65535, 1'b1, 0, 1'b1, 1'b0);
    add_pair(3, 1'b1, 1, 1'b1, 1'b1);
    drain();

    // random frames under a new setting per phase
    for (phase = 0; phase < 10; phase++) begin
      rel = phase[0];
      r   = $urandom_range(0, 3);
      if (phase == 0) begin
        thresh = '0;
      end else if (phase == 1) begin
        thresh = '1;
      end else if (r == 0) begin
        thresh = 18'($urandom);
      end else begin
        thresh = rel ? 18'($urandom_range(0, 20000)) : 18'($urandom_range(0, 3000));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(disr_pkg::REG_INLIER_THRESHOLD, thresh);
        write_reg(disr_pkg::REG_RELATIVE_MODE, {17'($urandom), rel});
      end else begin
        write_reg(disr_pkg::REG_RELATIVE_MODE, {17'($urandom), rel});
        write_reg(disr_pkg::REG_INLIER_THRESHOLD, thresh);
      end
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      pairs = 0;
      while (pairs < 90) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          len = $urandom_range(21, 60);
        end else begin
          len = $urandom_range(61, 150);
        end
        for (int i = 0; i < len; i++) begin
          add_random_pair(i == len - 1);
        end
        pairs += len;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
